FILE: rtl/dac_pkg.sv
`timescale 1ns / 1ps
// package: request and result types, calendar constants and month length table
package dac_pkg;

	localparam int ADD_WIDTH_DEF = 20;
	localparam int DAY_W         = 5;
	localparam int MONTH_W       = 4;
	localparam int YEAR_W        = 14;
	localparam int DAYS_W        = 20;
	localparam int WDAY_W        = 3;

	localparam int START_ORD_W   = 22;
	localparam int MAX_YEAR      = 9999;
	localparam int DAYS_400Y     = 146097;
	localparam int DAYS_100Y     = 36524;
	localparam int DAYS_4Y       = 1461;
	localparam int DAYS_1Y       = 365;
	localparam int YEARS_400     = 400;
	localparam int YEARS_100     = 100;
	localparam int YEARS_4       = 4;
	localparam int YEARS_1       = 1;
	localparam int WEEK          = 7;
	localparam int MONTHS        = 12;
	localparam int FEB           = 2;
	localparam int QUADS_100Y    = 24;
	localparam int LAST_CAP      = 3;

	typedef struct packed {
		logic [DAY_W-1:0]   start_day;
		logic [MONTH_W-1:0] start_month;
		logic [YEAR_W-1:0]  start_year;
		logic [DAYS_W-1:0]  days_to_add;
	} req_t;

	typedef struct packed {
		logic [DAY_W-1:0]   result_day;
		logic [MONTH_W-1:0] result_month;
		logic [YEAR_W-1:0]  result_year;
		logic [WDAY_W-1:0]  weekday;
		logic               bad_date;
	} rsp_t;

	function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
		input logic leap);
		logic [DAY_W-1:0] n;
		case (m)
			MONTH_W'(FEB): n = leap ? 5'd29 : 5'd28;
			4'd4:    n = 5'd30;
			4'd6:    n = 5'd30;
			4'd9:    n = 5'd30;
			4'd11:   n = 5'd30;
			default: n = 5'd31;
		endcase
		return n;
	endfunction

endpackage

FILE: rtl/gregorian_date_add_days.sv
`timescale 1ns / 1ps
// gregorian date plus day count with weekday, iterative over one shared unit
// a bad month, year or zero day gets its result strobe the cycle after acceptance;
//   a day past the month end returns after the forward year and month walk; otherwise
//   it adds the days, runs the weekday modulo steps, then walks years and months back
// throughput: one request at a time; busy stays high until the result strobe,
//   a new request is taken the cycle after it; the receiver cannot stall
// reset: arst_n clears the sequencer to idle, busy and done low
module gregorian_date_add_days
	import dac_pkg::*;
#(
	parameter int ADD_WIDTH = ADD_WIDTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  req_t req,
	output logic busy,
	output logic done,
	output rsp_t rsp
);

	localparam int AW    = (ADD_WIDTH < DAYS_W) ? ADD_WIDTH : DAYS_W;
	localparam int ORD_W = ((AW > START_ORD_W) ? AW : START_ORD_W) + 1;
	localparam int K7_W  = $clog2(ORD_W);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_FY   = 4'd1;
	localparam logic [3:0] S_FM   = 4'd2;
	localparam logic [3:0] S_ADD  = 4'd3;
	localparam logic [3:0] S_MOD  = 4'd4;
	localparam logic [3:0] S_DEC  = 4'd5;
	localparam logic [3:0] S_BY   = 4'd6;
	localparam logic [3:0] S_BM   = 4'd7;
	localparam logic [3:0] S_DONE = 4'd8;

	logic [3:0]         state_q;
	req_t               in_q;
	logic [ORD_W-1:0]   rem_q;
	logic [ORD_W-1:0]   acc_q;
	logic [1:0]         lvl_q;
	logic [1:0]         b_q;
	logic [4:0]         c_q;
	logic [1:0]         e_q;
	logic [MONTH_W-1:0] mon_q;
	logic [K7_W-1:0]    k7_q;
	logic [WDAY_W-1:0]  wd_q;
	logic               bad_q;

	logic [ORD_W-1:0]   op_a;
	logic [ORD_W-1:0]   op_b;
	logic [ORD_W-1:0]   op_inc;
	logic [ORD_W-1:0]   diff;
	logic [ORD_W-1:0]   sum;
	logic               ge;
	logic               leap;
	logic [DAY_W-1:0]   dim;
	logic [ORD_W-1:0]   day_blk;
	logic [ORD_W-1:0]   yr_blk;
	logic               cap;
	logic               take;
	logic               early_bad;

	assign leap = (e_q == 2'(LAST_CAP)) && ((c_q != 5'(QUADS_100Y)) || (b_q == 2'(LAST_CAP)));
	assign dim  = month_days(mon_q, leap);

	always_comb begin
		case (lvl_q)
			2'd0:    begin day_blk = ORD_W'(DAYS_400Y); yr_blk = ORD_W'(YEARS_400); end
			2'd1:    begin day_blk = ORD_W'(DAYS_100Y); yr_blk = ORD_W'(YEARS_100); end
			2'd2:    begin day_blk = ORD_W'(DAYS_4Y);   yr_blk = ORD_W'(YEARS_4);   end
			default: begin day_blk = ORD_W'(DAYS_1Y);   yr_blk = ORD_W'(YEARS_1);   end
		endcase
	end

	assign cap = ((lvl_q == 2'd1) && (b_q == 2'(LAST_CAP))) ||
		((lvl_q == 2'd3) && (e_q == 2'(LAST_CAP)));
	assign take = ge && !cap;

	// operand select for the shared unit
	always_comb begin
		op_a   = rem_q;
		op_b   = ORD_W'(1);
		op_inc = ORD_W'(0);
		case (state_q)
			S_FY: begin
				op_b   = yr_blk;
				op_inc = day_blk;
			end
			S_FM: begin
				op_inc = (mon_q == in_q.start_month) ? ORD_W'(in_q.start_day) : ORD_W'(dim);
			end
			S_ADD: begin
				op_inc = ORD_W'(in_q.days_to_add[AW-1:0]);
			end
			S_MOD: begin
				op_b = ORD_W'(WEEK) << k7_q;
			end
			S_DEC: begin
				op_a = acc_q;
			end
			S_BY: begin
				op_b   = day_blk;
				op_inc = yr_blk;
			end
			S_BM: begin
				op_b = ORD_W'(dim);
			end
			default: begin
				op_a = rem_q;
			end
		endcase
	end

	dac_unit #(
		.W(ORD_W)
	) u_unit (
		.a   (op_a),
		.b   (op_b),
		.acc (acc_q),
		.inc (op_inc),
		.diff(diff),
		.ge  (ge),
		.sum (sum)
	);

	assign early_bad = (req.start_month == '0) || (req.start_month > 4'(MONTHS)) ||
		(req.start_year == '0) || (req.start_year > 14'(MAX_YEAR)) || (req.start_day == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= early_bad ? S_DONE : S_FY;
					end
				end
				S_FY: begin
					if (!take && lvl_q == 2'd3) begin
						state_q <= S_FM;
					end
				end
				S_FM: begin
					if (mon_q == in_q.start_month) begin
						state_q <= (in_q.start_day > dim) ? S_DONE : S_ADD;
					end
				end
				S_ADD: state_q <= S_MOD;
				S_MOD: begin
					if (k7_q == '0) begin
						state_q <= S_DEC;
					end
				end
				S_DEC: state_q <= S_BY;
				S_BY: begin
					if (!take && lvl_q == 2'd3) begin
						state_q <= S_BM;
					end
				end
				S_BM: begin
					if (!(mon_q != 4'(MONTHS) && ge)) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				in_q  <= req;
				bad_q <= early_bad;
				rem_q <= ORD_W'(req.start_year) - ORD_W'(1);
				acc_q <= '0;
				lvl_q <= '0;
				b_q   <= '0;
				c_q   <= '0;
				e_q   <= '0;
				mon_q <= MONTH_W'(1);
			end
			S_FY, S_BY: begin
				if (take) begin
					rem_q <= diff;
					acc_q <= sum;
					case (lvl_q)
						2'd1:    b_q <= b_q + 2'd1;
						2'd2:    c_q <= c_q + 5'd1;
						2'd3:    e_q <= e_q + 2'd1;
						default: b_q <= b_q;
					endcase
				end else begin
					lvl_q <= lvl_q + 2'd1;
				end
			end
			S_FM: begin
				if (mon_q == in_q.start_month) begin
					bad_q <= in_q.start_day > dim;
				end else begin
					mon_q <= mon_q + 4'd1;
				end
				acc_q <= sum;
			end
			S_ADD: begin
				acc_q <= sum;
				rem_q <= sum;
				k7_q  <= K7_W'(ORD_W - 3);
			end
			S_MOD: begin
				if (ge) begin
					rem_q <= diff;
				end
				if (k7_q == '0) begin
					wd_q <= ge ? diff[WDAY_W-1:0] : rem_q[WDAY_W-1:0];
				end else begin
					k7_q <= k7_q - K7_W'(1);
				end
			end
			S_DEC: begin
				rem_q <= diff;
				acc_q <= ORD_W'(1);
				lvl_q <= '0;
				b_q   <= '0;
				c_q   <= '0;
				e_q   <= '0;
				mon_q <= MONTH_W'(1);
			end
			S_BM: begin
				if (mon_q != 4'(MONTHS) && ge) begin
					rem_q <= diff;
					mon_q <= mon_q + 4'd1;
				end
			end
			default: begin
				bad_q <= bad_q;
			end
		endcase
	end

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_DONE);

	always_comb begin
		if (bad_q) begin
			rsp.result_day   = in_q.start_day;
			rsp.result_month = in_q.start_month;
			rsp.result_year  = in_q.start_year;
			rsp.weekday      = '0;
			rsp.bad_date     = 1'b1;
		end else begin
			rsp.result_day   = rem_q[DAY_W-1:0] + 5'd1;
			rsp.result_month = mon_q;
			rsp.result_year  = acc_q[YEAR_W-1:0];
			rsp.weekday      = wd_q;
			rsp.bad_date     = 1'b0;
		end
	end

endmodule

FILE: rtl/dac_unit.sv
`timescale 1ns / 1ps
// shared arithmetic unit: compare and subtract, plus accumulate adder
module dac_unit
	import dac_pkg::*;
#(
	parameter int W = START_ORD_W + 1
) (
	input  logic [W-1:0] a,
	input  logic [W-1:0] b,
	input  logic [W-1:0] acc,
	input  logic [W-1:0] inc,
	output logic [W-1:0] diff,
	output logic         ge,
	output logic [W-1:0] sum
);

	logic [W:0] sub;

	assign sub  = {1'b0, a} - {1'b0, b};
	assign diff = sub[W-1:0];
	assign ge   = ~sub[W];
	assign sum  = acc + inc;

endmodule

FILE: rtl/dac_checker.sv
`timescale 1ns / 1ps
// port-level checker for the date adder, bound to the top level
module dac_checker
	import dac_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic start,
	input req_t req,
	input logic busy,
	input logic done,
	input rsp_t rsp
);

	// result strobe only while a request is in flight
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy) else $error("result strobe while idle");

	// ready again right after the result
	a_done_free: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy && !done) else $error("not idle after result");

	// an accepted request is always in flight next cycle
	a_accept: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("request dropped");

	// bad date gives weekday zero
	a_bad_wd: assert property (@(posedge clk) disable iff (!arst_n)
		done && rsp.bad_date |-> rsp.weekday == '0) else $error("weekday on bad date");

	// good result is a real date
	a_good: assert property (@(posedge clk) disable iff (!arst_n)
		done && !rsp.bad_date |-> rsp.weekday < 3'd7 && rsp.result_month != '0 &&
		rsp.result_month <= 4'd12 && rsp.result_day != '0) else $error("bad result date");

endmodule

bind gregorian_date_add_days dac_checker u_dac_checker (.*);
